/* rtl/shsp_pkg.sv */
`timescale 1ns / 1ps
// Package: command, motion and register codes and the half-step coil table for the positioner.
package shsp_pkg;

    localparam int POS_WIDTH_DEF  = 16;
    localparam int PHASE_STEPS    = 8;
    localparam int PHASE_W        = $clog2(PHASE_STEPS);
    localparam int CFG_W          = 16;
    localparam int TARGET_W       = 17;

    localparam logic [3:0] COILS_OFF = 4'hF;

    localparam logic [CFG_W-1:0] REL_STEPS_RST = 16'd1024;
    localparam logic [CFG_W-1:0] MAX_POS_RST   = 16'd4096;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_OPEN      = 3'd1,
        OP_CLOSE     = 3'd2,
        OP_HALF      = 3'd3,
        OP_MOVE_TO   = 3'd4,
        OP_STOP      = 3'd5,
        OP_RESET_POS = 3'd6
    } opcode_t;

    typedef enum logic [2:0] {
        MS_IDLE    = 3'd0,
        MS_CLOSED  = 3'd1,
        MS_OPEN    = 3'd2,
        MS_OPENING = 3'd3,
        MS_CLOSING = 3'd4,
        MS_MOVING  = 3'd5,
        MS_AT_POS  = 3'd6
    } motion_t;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_REL_STEPS = 2'd1,
        REG_MAX_POS   = 2'd2
    } cfg_reg_t;

    // Active-low coil pattern for a phase: A, AB, B, BC, C, CD, D, DA
    function automatic logic [3:0] coil_for(input logic [PHASE_W-1:0] ph);
        logic [3:0] seq;
        case (ph)
            3'd0:    seq = 4'h1;
            3'd1:    seq = 4'h3;
            3'd2:    seq = 4'h2;
            3'd3:    seq = 4'h6;
            3'd4:    seq = 4'h4;
            3'd5:    seq = 4'hC;
            3'd6:    seq = 4'h8;
            default: seq = 4'h9;
        endcase
        return ~seq;
    endfunction

endpackage

/* rtl/stepper_half_step_positioner_top.sv */
`timescale 1ns / 1ps
// Top level: half-step stepper positioner with command stream in and status stream out.
//
// s_axis carries one command per transaction (opcode, target_value); m_axis returns
// one status transaction per command, taken after the command has acted
// (coil_drive, motion_state, position_now, in_motion, steps_remaining).
// The cfg port writes the mode, the step count per move and the position clamp;
// zero writes to the step count and the clamp are ignored, a mode write
// stops the motor. Write configuration only while no transaction is in flight.
// Status path: the input register loads on acceptance; when the command acts,
// the status register loads with the state that the command leaves.
// Throughput: one command per cycle while the receiver takes status; the single pass
// of compare, increment and coil table lookup between the two registers sets this.
// Reset: coils released, phase 0, position 0, closed, relative mode, step count
// 1024, position clamp 4096; both channels empty.
// Stall: while the status register is held by the receiver, one further command
// waits in the input register and s_tready drops; nothing is lost.
module stepper_half_step_positioner_top
    import shsp_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] opcode, [19:3] target_value, [23:20] zero
    input  logic [23:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // coil_drive, motion_state, position_now, in_motion, steps_remaining, zero fill
    output logic [((4 + 3 + POS_WIDTH + 1 + CFG_W + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int OUT_BITS  = 4 + 3 + POS_WIDTH + 1 + CFG_W;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // input register
    logic                      in_valid_reg;
    logic [2:0]                op_reg;
    logic [TARGET_W-1:0]       tgt_reg;
    logic                      advance;

    // configuration
    logic                      mode_reg, mode_next;
    logic [CFG_W-1:0]          rel_steps_reg, rel_steps_next;
    logic [CFG_W-1:0]          max_pos_reg, max_pos_next;

    // motor state
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic [2:0]                motion_reg, motion_next;
    logic [CFG_W-1:0]          budget_reg, budget_next;
    logic [POS_WIDTH-1:0]      cur_pos_reg, cur_pos_next;
    logic [POS_WIDTH-1:0]      goal_pos_reg, goal_pos_next;
    logic                      moving_reg, moving_next;
    logic [3:0]                coil_reg, coil_next;

    // status register
    logic                      out_valid_reg;
    logic [OUT_BYTES*8-1:0]    out_data_reg;

    logic [CFG_W-1:0]          goal_clamp;
    logic [POS_WIDTH-1:0]      goal_w;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        if (tgt_reg[TARGET_W-1])
            goal_clamp = '0;
        else if (tgt_reg[CFG_W-1:0] > max_pos_reg)
            goal_clamp = max_pos_reg;
        else
            goal_clamp = tgt_reg[CFG_W-1:0];
        goal_w = POS_WIDTH'(goal_clamp);
    end

    always_comb
    begin
        mode_next      = mode_reg;
        rel_steps_next = rel_steps_reg;
        max_pos_next   = max_pos_reg;
        phase_next     = phase_reg;
        motion_next    = motion_reg;
        budget_next    = budget_reg;
        cur_pos_next   = cur_pos_reg;
        goal_pos_next  = goal_pos_reg;
        moving_next    = moving_reg;
        coil_next      = coil_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODE:
                begin
                    budget_next = '0;
                    moving_next = 1'b0;
                    coil_next   = COILS_OFF;
                    mode_next   = cfg_wdata[0];
                    motion_next = cfg_wdata[0] ? MS_AT_POS : MS_CLOSED;
                end
                REG_REL_STEPS:
                begin
                    if (cfg_wdata != '0)
                        rel_steps_next = cfg_wdata;
                end
                REG_MAX_POS:
                begin
                    if (cfg_wdata != '0)
                        max_pos_next = cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
        else if (advance)
        begin
            case (op_reg)
                OP_TICK:
                begin
                    if (!mode_reg)
                    begin
                        if (budget_reg != '0)
                        begin
                            if (motion_reg == MS_OPENING)
                            begin
                                phase_next = phase_reg + 1'b1;
                                coil_next  = coil_for(phase_reg + 1'b1);
                            end
                            else if (motion_reg == MS_CLOSING)
                            begin
                                phase_next = phase_reg - 1'b1;
                                coil_next  = coil_for(phase_reg - 1'b1);
                            end
                            budget_next = budget_reg - 1'b1;
                            if (budget_reg == CFG_W'(1))
                            begin
                                if (motion_reg == MS_OPENING)
                                    motion_next = MS_OPEN;
                                else if (motion_reg == MS_CLOSING)
                                    motion_next = MS_CLOSED;
                                coil_next = COILS_OFF;
                            end
                        end
                    end
                    else if (moving_reg)
                    begin
                        if (cur_pos_reg == goal_pos_reg)
                        begin
                            moving_next = 1'b0;
                            motion_next = MS_AT_POS;
                            coil_next   = COILS_OFF;
                        end
                        else if (cur_pos_reg < goal_pos_reg)
                        begin
                            phase_next   = phase_reg + 1'b1;
                            coil_next    = coil_for(phase_reg + 1'b1);
                            cur_pos_next = cur_pos_reg + 1'b1;
                        end
                        else
                        begin
                            phase_next   = phase_reg - 1'b1;
                            coil_next    = coil_for(phase_reg - 1'b1);
                            cur_pos_next = cur_pos_reg - 1'b1;
                        end
                    end
                end
                OP_OPEN:
                begin
                    motion_next = MS_OPENING;
                    budget_next = rel_steps_reg;
                end
                OP_CLOSE:
                begin
                    motion_next = MS_CLOSING;
                    budget_next = rel_steps_reg;
                end
                OP_HALF:
                begin
                    motion_next = MS_OPENING;
                    budget_next = rel_steps_reg >> 1;
                end
                OP_MOVE_TO:
                begin
                    if (mode_reg)
                    begin
                        goal_pos_next = goal_w;
                        if (cur_pos_reg == goal_w)
                        begin
                            moving_next = 1'b0;
                            motion_next = MS_AT_POS;
                        end
                        else
                        begin
                            moving_next = 1'b1;
                            motion_next = MS_MOVING;
                        end
                    end
                end
                OP_STOP:
                begin
                    budget_next = '0;
                    moving_next = 1'b0;
                    motion_next = MS_IDLE;
                    coil_next   = COILS_OFF;
                end
                OP_RESET_POS:
                begin
                    cur_pos_next  = '0;
                    goal_pos_next = '0;
                    motion_next   = MS_AT_POS;
                    moving_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            rel_steps_reg <= REL_STEPS_RST;
            max_pos_reg   <= MAX_POS_RST;
            phase_reg     <= '0;
            motion_reg    <= MS_CLOSED;
            budget_reg    <= '0;
            cur_pos_reg   <= '0;
            goal_pos_reg  <= '0;
            moving_reg    <= 1'b0;
            coil_reg      <= COILS_OFF;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            mode_reg      <= mode_next;
            rel_steps_reg <= rel_steps_next;
            max_pos_reg   <= max_pos_next;
            phase_reg     <= phase_next;
            motion_reg    <= motion_next;
            budget_reg    <= budget_next;
            cur_pos_reg   <= cur_pos_next;
            goal_pos_reg  <= goal_pos_next;
            moving_reg    <= moving_next;
            coil_reg      <= coil_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg  <= s_tdata[2:0];
            tgt_reg <= s_tdata[TARGET_W+2:3];
        end
        if (advance)
            out_data_reg <= (OUT_BYTES*8)'({budget_next, moving_next, cur_pos_next,
                                            motion_next, coil_next});
    end

    // status register loads whenever a command acts
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg)
        else $error("status transaction not presented after command");

    // a held command is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(op_reg)))
        else $error("pending command lost while status stalled");

    // a move in progress only exists in position mode
    assert property (@(posedge clk) disable iff (!rst_n) moving_reg |-> mode_reg)
        else $error("move active in relative mode");

    // coils are either released or show the pattern of the current phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (coil_reg == COILS_OFF) || (coil_reg == coil_for(phase_reg)))
        else $error("coil pattern out of step with phase");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench: half-step positioner command stream checked against a cycle-free status predictor.
module tb_top
    import shsp_pkg::*;
();

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PHASES  = 12;
    localparam int unsigned PHASE_CMDS     = 160;
    // Active-high coil pattern per phase, phase 0 in the low nibble
    localparam logic [31:0] ENERGISE_SEQ   = 32'h9_8_C_4_6_2_3_1;

    typedef struct packed {
        logic [15:0] budget;
        logic        moving;
        logic [15:0] pos;
        logic [2:0]  motion;
        logic [3:0]  coil;
    } status_t;

    typedef struct {
        bit          is_cfg;
        cfg_reg_t    cfg_idx;
        logic [15:0] wdata;
        logic [2:0]  op;
        logic [16:0] tgt;
        bit          has_want;
        status_t     want;
    } dir_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [2:0] opcode, [19:3] target_value, [23:20] zero
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [3:0] coil_drive, [6:4] motion_state, [22:7] position_now, [23] in_motion,
    // [39:24] steps_remaining
    logic [39:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;

    // Predictor state
    logic        pos_mode;
    logic [15:0] rel_steps;
    logic [15:0] clamp_limit;
    logic [2:0]  phase;
    motion_t     motion;
    logic [15:0] budget;
    logic [15:0] pos;
    logic [15:0] goal;
    logic        moving;
    logic [3:0]  coils;

    status_t     pending_status [$];
    dir_row_t    directed_tbl [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned ready_hold     = 0;
    int unsigned ready_gap;
    bit          quiet          = 1'b0;

    stepper_half_step_positioner_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void step_phase(input bit fwd);
        phase = fwd ? phase + 3'd1 : phase - 3'd1;
        coils = ~ENERGISE_SEQ[phase*4 +: 4];
    endfunction

    function automatic void halt_motor();
        budget = '0;
        moving = 1'b0;
        motion = MS_IDLE;
        coils  = COILS_OFF;
    endfunction

    function automatic void reset_predictor();
        pos_mode    = 1'b0;
        rel_steps   = REL_STEPS_RST;
        clamp_limit = MAX_POS_RST;
        phase       = '0;
        motion      = MS_CLOSED;
        budget      = '0;
        pos         = '0;
        goal        = '0;
        moving      = 1'b0;
        coils       = COILS_OFF;
    endfunction

    function automatic void apply_register(input cfg_reg_t idx, input logic [15:0] val);
        case (idx)
            REG_MODE:
            begin
                halt_motor();
                pos_mode = val[0];
                motion   = pos_mode ? MS_AT_POS : MS_CLOSED;
            end
            REG_REL_STEPS:
                if (val != 0)
                    rel_steps = val;
            REG_MAX_POS:
                if (val != 0)
                    clamp_limit = val;
            default: ;
        endcase
    endfunction

    function automatic status_t status_after(input logic [2:0] op, input logic [16:0] tgt);
        status_t s;
        case (op)
            OP_TICK:
                if (!pos_mode)
                begin
                    if (budget != 0)
                    begin
                        if (motion == MS_OPENING)
                            step_phase(1'b1);
                        else if (motion == MS_CLOSING)
                            step_phase(1'b0);
                        budget = budget - 16'd1;
                        if (budget == 0)
                        begin
                            if (motion == MS_OPENING)
                                motion = MS_OPEN;
                            else if (motion == MS_CLOSING)
                                motion = MS_CLOSED;
                            coils = COILS_OFF;
                        end
                    end
                end
                else if (moving)
                begin
                    if (pos == goal)
                    begin
                        moving = 1'b0;
                        motion = MS_AT_POS;
                        coils  = COILS_OFF;
                    end
                    else if (pos < goal)
                    begin
                        step_phase(1'b1);
                        pos = pos + 16'd1;
                    end
                    else
                    begin
                        step_phase(1'b0);
                        pos = pos - 16'd1;
                    end
                end
            OP_OPEN:
            begin
                motion = MS_OPENING;
                budget = rel_steps;
            end
            OP_CLOSE:
            begin
                motion = MS_CLOSING;
                budget = rel_steps;
            end
            OP_HALF:
            begin
                motion = MS_OPENING;
                budget = rel_steps >> 1;
            end
            OP_MOVE_TO:
                if (pos_mode)
                begin
                    if (tgt[16])
                        goal = '0;
                    else if (tgt[15:0] > clamp_limit)
                        goal = clamp_limit;
                    else
                        goal = tgt[15:0];
                    moving = (pos != goal);
                    motion = moving ? MS_MOVING : MS_AT_POS;
                end
            OP_STOP:
                halt_motor();
            OP_RESET_POS:
            begin
                pos    = '0;
                goal   = '0;
                motion = MS_AT_POS;
                moving = 1'b0;
            end
            default: ;
        endcase
        s.coil   = coils;
        s.motion = motion;
        s.pos    = pos;
        s.moving = moving;
        s.budget = budget;
        return s;
    endfunction

    function automatic status_t st(input logic [3:0] c, input motion_t m, input logic [15:0] p,
                                   input logic mv, input logic [15:0] b);
        status_t s;
        s.coil   = c;
        s.motion = m;
        s.pos    = p;
        s.moving = mv;
        s.budget = b;
        return s;
    endfunction

    function automatic dir_row_t cmd_row(input logic [2:0] op, input logic [16:0] tgt);
        dir_row_t r;
        r.is_cfg   = 1'b0;
        r.cfg_idx  = REG_MODE;
        r.wdata    = '0;
        r.op       = op;
        r.tgt      = tgt;
        r.has_want = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic dir_row_t chk_row(input logic [2:0] op, input logic [16:0] tgt,
                                         input status_t want);
        dir_row_t r;
        r          = cmd_row(op, tgt);
        r.has_want = 1'b1;
        r.want     = want;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input cfg_reg_t idx, input logic [15:0] val);
        dir_row_t r;
        r         = cmd_row(OP_TICK, '0);
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.wdata   = val;
        return r;
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [16:0] tgt, input bit has_want,
                            input status_t want);
        int unsigned g;
        status_t     pred;
        g = pick_gap();
        if (g != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, tgt, op};
        do
            @(posedge clk);
        while (!s_tready);
        pred = status_after(op, tgt);
        pending_status.push_back(has_want ? want : pred);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_register(idx, val);
    endtask

    task automatic random_cmd();
        int unsigned r;
        int unsigned t;
        logic [2:0]  op;
        logic [16:0] tgt;
        r = $urandom_range(0, 99);
        if (!pos_mode)
        begin
            if (r < 70)      op = OP_TICK;
            else if (r < 76) op = OP_OPEN;
            else if (r < 82) op = OP_CLOSE;
            else if (r < 87) op = OP_HALF;
            else if (r < 90) op = OP_STOP;
            else if (r < 93) op = OP_RESET_POS;
            else if (r < 96) op = OP_MOVE_TO;
            else             op = 3'd7;
        end
        else
        begin
            if (r < 62)      op = OP_TICK;
            else if (r < 84) op = OP_MOVE_TO;
            else if (r < 87) op = OP_OPEN;
            else if (r < 89) op = OP_CLOSE;
            else if (r < 91) op = OP_HALF;
            else if (r < 94) op = OP_STOP;
            else if (r < 97) op = OP_RESET_POS;
            else             op = 3'd7;
        end
        t = $urandom_range(0, 9);
        if (t < 6)
            tgt = 17'($urandom_range(0, int'(clamp_limit) + 2));
        else if (t < 8)
            tgt = 17'($urandom);
        else
            tgt = 17'h1FFFF - 17'($urandom_range(0, 3));
        send_cmd(op, tgt, 1'b0, '0);
    endtask

    task automatic compare_field(input string fname, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Status transaction checker
    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_status.size() == 0)
            begin
                $display("%0t: unexpected status transaction, expected none, got %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                compare_field("coil_drive", 16'(want.coil), 16'(got.coil));
                compare_field("motion_state", 16'(want.motion), 16'(got.motion));
                compare_field("position_now", want.pos, got.pos);
                compare_field("in_motion", 16'(want.moving), 16'(got.moving));
                compare_field("steps_remaining", want.budget, got.budget);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_gap = pick_gap();
            if (ready_gap == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready   <= 1'b0;
                ready_hold <= ready_gap - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] rel_val;
        logic [15:0] max_val;
        logic [15:0] mode_val;

        reset_predictor();

        directed_tbl.push_back(chk_row(OP_TICK, '0,
                               st(COILS_OFF, MS_CLOSED, 16'd0, 1'b0, 16'd0)));
        // unused opcode, all target bits high
        directed_tbl.push_back(chk_row(3'd7, 17'h1FFFF,
                               st(COILS_OFF, MS_CLOSED, 16'd0, 1'b0, 16'd0)));
        // move_to ignored in relative mode
        directed_tbl.push_back(chk_row(OP_MOVE_TO, 17'd100,
                               st(COILS_OFF, MS_CLOSED, 16'd0, 1'b0, 16'd0)));
        directed_tbl.push_back(chk_row(OP_OPEN, '0,
                               st(COILS_OFF, MS_OPENING, 16'd0, 1'b0, 16'd1024)));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cmd_row(OP_CLOSE, '0));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(chk_row(OP_STOP, '0,
                               st(COILS_OFF, MS_IDLE, 16'd0, 1'b0, 16'd0)));
        directed_tbl.push_back(chk_row(OP_HALF, '0,
                               st(COILS_OFF, MS_OPENING, 16'd0, 1'b0, 16'd512)));
        directed_tbl.push_back(chk_row(OP_RESET_POS, '0,
                               st(COILS_OFF, MS_AT_POS, 16'd0, 1'b0, 16'd512)));
        // budget drains without stepping
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cfg_row(REG_REL_STEPS, 16'd1));
        directed_tbl.push_back(cfg_row(REG_REL_STEPS, 16'd0));
        // half of a single step leaves nothing to do
        directed_tbl.push_back(chk_row(OP_HALF, '0,
                               st(COILS_OFF, MS_OPENING, 16'd0, 1'b0, 16'd0)));
        directed_tbl.push_back(chk_row(OP_TICK, '0,
                               st(COILS_OFF, MS_OPENING, 16'd0, 1'b0, 16'd0)));
        directed_tbl.push_back(cfg_row(REG_REL_STEPS, 16'd2));
        directed_tbl.push_back(cmd_row(OP_OPEN, '0));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        // last step releases the coils
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cfg_row(REG_MAX_POS, 16'd3));
        directed_tbl.push_back(cfg_row(REG_MODE, 16'd1));
        // most negative target clamps to zero, already there
        directed_tbl.push_back(chk_row(OP_MOVE_TO, 17'h10000,
                               st(COILS_OFF, MS_AT_POS, 16'd0, 1'b0, 16'd0)));
        directed_tbl.push_back(cmd_row(OP_MOVE_TO, 17'h0FFFF));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        // move to where it already is: coils untouched
        directed_tbl.push_back(cmd_row(OP_MOVE_TO, 17'd3));
        directed_tbl.push_back(cmd_row(OP_OPEN, '0));
        directed_tbl.push_back(cmd_row(OP_MOVE_TO, 17'd1));
        directed_tbl.push_back(cmd_row(OP_TICK, '0));
        directed_tbl.push_back(cmd_row(OP_RESET_POS, '0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tbl[i])
        begin
            if (directed_tbl[i].is_cfg)
                write_reg(directed_tbl[i].cfg_idx, directed_tbl[i].wdata);
            else
                send_cmd(directed_tbl[i].op, directed_tbl[i].tgt, directed_tbl[i].has_want,
                         directed_tbl[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            quiet    = (p % 4 == 3);
            rel_val  = 16'($urandom_range(1, 16));
            max_val  = 16'($urandom_range(2, 48));
            mode_val = 16'($urandom);
            case (p)
                0:
                begin
                    rel_val  = 16'd1;
                    max_val  = 16'd1;
                    mode_val = {15'($urandom), 1'b0};
                end
                1:
                begin
                    max_val  = 16'd1;
                    mode_val = {15'($urandom), 1'b1};
                end
                2:       mode_val = {15'($urandom), 1'b0};
                3:
                begin
                    rel_val  = 16'hFFFF;
                    max_val  = 16'hFFFF;
                    mode_val = {15'($urandom), 1'b1};
                end
                default: ;
            endcase
            write_reg(REG_REL_STEPS, rel_val);
            write_reg(REG_MAX_POS, max_val);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_REL_STEPS : REG_MAX_POS, 16'd0);
            write_reg(REG_MODE, mode_val);
            repeat (PHASE_CMDS) random_cmd();
        end

        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/shsp_pkg.sv
rtl/stepper_half_step_positioner_top.sv
dv/tb_top.sv
